### hw/rtl/btbp_pkg.sv
`default_nettype none

package btbp_pkg;

	localparam int unsigned ENTRIES = 16;
	localparam int unsigned PC_W    = 32;
	localparam int unsigned OFF_W   = 16;
	localparam int unsigned CNT_W   = 32;

	typedef logic [PC_W-1:0] pc_t;
	typedef logic [1:0]      ctr_t;

	localparam ctr_t CTR_MIN = 2'd0;
	localparam ctr_t CTR_MAX = 2'd3;

	// Search beat handed from cell to cell.
	typedef struct packed {
		pc_t  pc;
		logic taken;
		logic claimed;   // an earlier cell already owns this branch
		logic hit;
		logic mis;       // prediction disagreed with the outcome
	} tok_t;

	// Two-bit saturating counter step toward the outcome.
	function automatic ctr_t ctr_next(input ctr_t c, input logic tk);
		ctr_t n;
		n = c;
		if (tk) begin
			if (c != CTR_MAX) n = c + 2'd1;
		end else begin
			if (c != CTR_MIN) n = c - 2'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/btb_two_bit_branch_predictor_unit.sv
// The search beat walks the cell chain one entry per cycle, then its flags are
// registered into the result; a new beat is taken after the result leaves.
// Reset (arst_n, async, active low): table empty, counters and totals zero,
// no beat in flight; entry addresses are written on allocation only.
`default_nettype none

module btb_two_bit_branch_predictor_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [btbp_pkg::PC_W-1:0]  branch_pc,
	input  wire logic                       taken,
	input  wire logic signed [btbp_pkg::OFF_W-1:0] branch_offset,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            mispredict,
	output logic [btbp_pkg::PC_W-1:0]       redirect_pc,
	output logic [btbp_pkg::PC_W-1:0]       branch_target,
	output logic                            table_hit,
	output logic                            table_full,
	output logic [btbp_pkg::CNT_W-1:0]      correct_total,
	output logic [btbp_pkg::CNT_W-1:0]      wrong_total
);
	import btbp_pkg::*;

	// Control: one branch in the block at a time.
	logic busy_q;
	logic out_vld_q;
	logic in_fire;
	logic out_fire;

	// Result registers.
	logic            mis_q;
	pc_t             redir_q;
	pc_t             target_q;
	logic            hit_q;
	logic            full_q;
	logic [CNT_W-1:0] correct_q;
	logic [CNT_W-1:0] wrong_q;

	// Cell chain links; link 0 is the incoming beat, link ENTRIES the exit.
	tok_t               link [ENTRIES+1];
	logic [ENTRIES:0]   link_vld;

	pc_t  off_bytes;
	tok_t exit_tok;

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_vld_q && out_ready;

	// Word offset to bytes, sign extended.
	assign off_bytes = {{(PC_W-OFF_W-2){branch_offset[OFF_W-1]}}, branch_offset, 2'b00};

	always_comb begin
		link[0]         = '0;
		link[0].pc      = branch_pc;
		link[0].taken   = taken;
		link[0].claimed = 1'b0;
		link[0].hit     = 1'b0;
		link[0].mis     = taken;   // unclaimed at the end: table full, predicted not taken
	end
	assign link_vld[0] = in_fire;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		btbp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_vld_i (link_vld[g]),
			.tok_i     (link[g]),
			.tok_vld_o (link_vld[g+1]),
			.tok_o     (link[g+1])
		);
	end

	assign exit_tok = link[ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
			correct_q <= '0;
			wrong_q   <= '0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (out_fire) begin
				busy_q <= 1'b0;
			end

			if (link_vld[ENTRIES]) begin
				out_vld_q <= 1'b1;
				if (exit_tok.mis) begin
					wrong_q <= wrong_q + CNT_W'(1);
				end else begin
					correct_q <= correct_q + CNT_W'(1);
				end
			end else if (out_fire) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers: target on entry, flags when the beat leaves the chain.
	always_ff @(posedge clk) begin
		if (in_fire) target_q <= branch_pc + PC_W'(4) + off_bytes;
		if (link_vld[ENTRIES]) begin
			mis_q   <= exit_tok.mis;
			redir_q <= exit_tok.mis ? exit_tok.pc : '0;
			hit_q   <= exit_tok.hit;
			full_q  <= !exit_tok.claimed;
		end
	end

	assign out_valid     = out_vld_q;
	assign mispredict    = mis_q;
	assign redirect_pc   = redir_q;
	assign branch_target = target_q;
	assign table_hit     = hit_q;
	assign table_full    = full_q;
	assign correct_total = correct_q;
	assign wrong_total   = wrong_q;

`ifndef SYNTHESIS
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(link_vld) <= 1)
		else $error("more than one beat in the cell chain");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_vld_q && link_vld[ENTRIES:1] == '0))
		else $error("ready while a branch is in flight");

	a_one_total: assert property (@(posedge clk) disable iff (!arst_n)
		link_vld[ENTRIES] |=> (CNT_W'(correct_q + wrong_q) ==
			CNT_W'($past(correct_q) + $past(wrong_q) + CNT_W'(1))))
		else $error("totals did not advance by exactly one");

	a_hit_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(hit_q && full_q))
		else $error("hit and full together");
`endif

endmodule

`default_nettype wire

### hw/rtl/btbp_cell.sv
`default_nettype none

// One table entry. Looks at the passing beat, claims it on a match or,
// when still unused, allocates itself; then hands the beat on.
module btbp_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          tok_vld_i,
	input  wire btbp_pkg::tok_t tok_i,
	output logic               tok_vld_o,
	output btbp_pkg::tok_t     tok_o
);
	import btbp_pkg::*;

	logic used_q;
	pc_t  addr_q;
	ctr_t ctr_q;
	logic tok_vld_q;
	tok_t tok_q;

	logic match;
	logic alloc;
	tok_t tok_nx;

	assign match = tok_vld_i && !tok_i.claimed && used_q && (addr_q == tok_i.pc);
	assign alloc = tok_vld_i && !tok_i.claimed && !used_q;

	always_comb begin
		tok_nx = tok_i;
		if (match) begin
			tok_nx.claimed = 1'b1;
			tok_nx.hit     = 1'b1;
			tok_nx.mis     = ctr_q[1] != tok_i.taken;
		end else if (alloc) begin
			tok_nx.claimed = 1'b1;
			tok_nx.mis     = tok_i.taken;  // fresh entry predicts not taken
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			ctr_q     <= CTR_MIN;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_vld_i;
			if (match) begin
				ctr_q <= ctr_next(ctr_q, tok_i.taken);
			end else if (alloc) begin
				used_q <= 1'b1;
				ctr_q  <= ctr_next(CTR_MIN, tok_i.taken);
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
		if (alloc) addr_q <= tok_i.pc;
	end

	assign tok_vld_o = tok_vld_q;
	assign tok_o     = tok_q;

endmodule

`default_nettype wire
